// ===== sv/eius_pkg.sv =====
// ----------------------------------------------------------------------------
// eius_pkg
// shared constants, frame offsets, job type and helper for the ethernet/ipv4/
// udp frame statistics core
// ----------------------------------------------------------------------------
`default_nettype none

package eius_pkg;

  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int CNT_W_MAX         = 64;
  localparam int ETH_HEADER_BYTES  = 14;
  localparam int IP_HDR_BYTES      = 20;
  localparam int TCP_HDR_BYTES     = 20;
  localparam int UDP_HDR_BYTES     = 8;
  localparam int NUM_COUNTERS      = 18;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [15:0] OFF_L4      = 16'(ETH_HEADER_BYTES + IP_HDR_BYTES);
  localparam logic [15:0] LEN_ETH_MIN = 16'(ETH_HEADER_BYTES);
  localparam logic [15:0] LEN_TCP_MIN = 16'(ETH_HEADER_BYTES + IP_HDR_BYTES + TCP_HDR_BYTES);
  localparam logic [15:0] LEN_UDP_MIN = 16'(ETH_HEADER_BYTES + IP_HDR_BYTES + UDP_HDR_BYTES);
  localparam logic [15:0] UDP_HDR_LEN = 16'(UDP_HDR_BYTES);

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] CSUM_GOOD  = 16'hFFFF;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [2:0] CLS_NON_IP = 3'd0;
  localparam logic [2:0] CLS_TCP    = 3'd1;
  localparam logic [2:0] CLS_UDP    = 3'd2;
  localparam logic [2:0] CLS_OTHER  = 3'd3;
  localparam logic [2:0] CLS_TRUNC  = 3'd4;

  localparam logic [1:0] CSUM_NONE = 2'd0;
  localparam logic [1:0] CSUM_OK   = 2'd1;
  localparam logic [1:0] CSUM_BAD  = 2'd2;

  localparam int CNT_FRAMES   = 0;
  localparam int CNT_NON_IP   = 1;
  localparam int CNT_IP       = 2;
  localparam int CNT_TCP      = 3;
  localparam int CNT_UDP      = 4;
  localparam int CNT_OTHER    = 5;
  localparam int CNT_TRUNC    = 6;
  localparam int CNT_FIN      = 7;
  localparam int CNT_CSUM_OK  = 13;
  localparam int CNT_CSUM_BAD = 14;
  localparam int CNT_CSUM_OMIT = 15;
  localparam int CNT_MIN_LEN  = 16;
  localparam int CNT_MAX_LEN  = 17;

  typedef struct packed {
    logic        kind;
    logic [15:0] len;
    logic        is_ip;
    logic        is_tcp;
    logic        is_udp;
    logic [15:0] csum;
    logic [15:0] udp_len;
    logic        chk_zero;
    logic        payload_done;
    logic [5:0]  flags;
    logic [4:0]  idx;
  } job_t;

  // one's-complement add with end-around carry
  function automatic logic [15:0] eac_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/eius_front.sv =====
// ----------------------------------------------------------------------------
// eius_front
// byte parser: tracks frame offsets, captures header fields, runs the udp
// one's-complement sum and emits one job per counter read or frame end
// ----------------------------------------------------------------------------
`default_nettype none

module eius_front import eius_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_command,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic [4:0] in_counter_index,
  output logic            job_valid,
  output job_t            job,
  input  wire logic       job_ready
);

  localparam logic [15:0] POS_ETYPE_HI = 16'(ETH_HEADER_BYTES - 2);
  localparam logic [15:0] POS_ETYPE_LO = 16'(ETH_HEADER_BYTES - 1);
  localparam logic [15:0] POS_PROTO    = 16'(ETH_HEADER_BYTES + 9);
  localparam logic [15:0] POS_SUM_LO   = 16'(ETH_HEADER_BYTES + 12);
  localparam logic [15:0] POS_FLAGS    = OFF_L4 + 16'd13;
  localparam logic [15:0] POS_ULEN_LO  = OFF_L4 + 16'd5;
  localparam logic [15:0] POS_UCHK_LO  = OFF_L4 + 16'd7;
  localparam logic [15:0] POS_PAYLOAD  = OFF_L4 + UDP_HDR_LEN;

  logic [15:0] pos_r, pos_upd, pos_nxt;
  logic [15:0] etype_r, etype_upd, etype_nxt;
  logic [7:0]  proto_r, proto_upd, proto_nxt;
  logic [5:0]  flags_r, flags_upd, flags_nxt;
  logic [7:0]  hold_r, hold_upd, hold_nxt;
  logic [15:0] csum_r, csum_upd, csum_nxt;
  logic [15:0] ulen_r, ulen_upd, ulen_nxt;
  logic        chkz_r, chkz_upd, chkz_nxt;
  logic [15:0] left_r, left_upd, left_nxt;
  logic        odd_r, odd_upd, odd_nxt;
  logic        accept, data_beat, frame_end;
  logic [15:0] word;

  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign data_beat = accept && (in_command == CMD_DATA);
  assign frame_end = data_beat && in_last_byte;
  assign word      = {hold_r, in_data_byte};

  always_comb begin
    pos_upd   = pos_r;
    etype_upd = etype_r;
    proto_upd = proto_r;
    flags_upd = flags_r;
    hold_upd  = hold_r;
    csum_upd  = csum_r;
    ulen_upd  = ulen_r;
    chkz_upd  = chkz_r;
    left_upd  = left_r;
    odd_upd   = odd_r;
    if (data_beat) begin
      if (pos_r != 16'hFFFF) begin
        pos_upd = pos_r + 16'd1;
      end
      if (pos_r == POS_ETYPE_HI) etype_upd[15:8] = in_data_byte;
      if (pos_r == POS_ETYPE_LO) etype_upd[7:0] = in_data_byte;
      if (pos_r == POS_PROTO) proto_upd = in_data_byte;
      if (pos_r == POS_FLAGS) flags_upd = in_data_byte[5:0];
      if (pos_r >= POS_SUM_LO && pos_r < POS_PAYLOAD) begin
        if (!pos_r[0]) begin
          hold_upd = in_data_byte;
        end else begin
          csum_upd = eac_add(csum_r, word);
          if (pos_r == POS_ULEN_LO) ulen_upd = word;
          if (pos_r == POS_UCHK_LO) chkz_upd = (word == 16'h0000);
        end
        if (pos_r == POS_UCHK_LO && etype_r == ETYPE_IPV4 && proto_r == PROTO_UDP) begin
          left_upd = (ulen_r >= UDP_HDR_LEN) ? ulen_r - UDP_HDR_LEN : 16'd0;
        end
      end else if (pos_r >= POS_PAYLOAD && left_r != 16'd0) begin
        if (!odd_r) begin
          hold_upd = in_data_byte;
          if (left_r == 16'd1) csum_upd = eac_add(csum_r, {in_data_byte, 8'h00});
        end else begin
          csum_upd = eac_add(csum_r, word);
        end
        odd_upd  = !odd_r;
        left_upd = left_r - 16'd1;
      end
    end
  end

  always_comb begin
    pos_nxt   = frame_end ? 16'd0 : pos_upd;
    etype_nxt = frame_end ? 16'd0 : etype_upd;
    proto_nxt = frame_end ? 8'd0  : proto_upd;
    flags_nxt = frame_end ? 6'd0  : flags_upd;
    hold_nxt  = frame_end ? 8'd0  : hold_upd;
    csum_nxt  = frame_end ? 16'd0 : csum_upd;
    ulen_nxt  = frame_end ? 16'd0 : ulen_upd;
    chkz_nxt  = frame_end ? 1'b0  : chkz_upd;
    left_nxt  = frame_end ? 16'd0 : left_upd;
    odd_nxt   = frame_end ? 1'b0  : odd_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      etype_r <= '0;
      proto_r <= '0;
      flags_r <= '0;
      hold_r  <= '0;
      csum_r  <= '0;
      ulen_r  <= '0;
      chkz_r  <= 1'b0;
      left_r  <= '0;
      odd_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      proto_r <= proto_nxt;
      flags_r <= flags_nxt;
      hold_r  <= hold_nxt;
      csum_r  <= csum_nxt;
      ulen_r  <= ulen_nxt;
      chkz_r  <= chkz_nxt;
      left_r  <= left_nxt;
      odd_r   <= odd_nxt;
    end
  end

  assign job_valid = accept && ((in_command == CMD_READ) || in_last_byte);

  always_comb begin
    job = '0;
    if (in_command == CMD_READ) begin
      job.kind = KIND_READ;
      job.idx  = in_counter_index;
    end else begin
      job.kind         = KIND_FRAME;
      job.len          = pos_upd;
      job.is_ip        = (etype_upd == ETYPE_IPV4);
      job.is_tcp       = (proto_upd == PROTO_TCP);
      job.is_udp       = (proto_upd == PROTO_UDP);
      job.csum         = csum_upd;
      job.udp_len      = ulen_upd;
      job.chk_zero     = chkz_upd;
      job.payload_done = (left_upd == 16'd0);
      job.flags        = flags_upd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/eius_queue.sv =====
// ----------------------------------------------------------------------------
// eius_queue
// short job queue between parser and statistics engine
// ----------------------------------------------------------------------------
`default_nettype none

module eius_queue import eius_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  job_t      push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);

  job_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== sv/eius_back.sv =====
// ----------------------------------------------------------------------------
// eius_back
// statistics engine: classifies finished frames, closes the udp checksum,
// updates saturating counters and answers counter reads
// ----------------------------------------------------------------------------
`default_nettype none

module eius_back import eius_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic        out_result_kind,
  output logic [2:0]  out_frame_class,
  output logic [5:0]  out_tcp_flag_bits,
  output logic [1:0]  out_checksum_status,
  output logic        out_checksum_omitted,
  output logic [15:0] out_frame_length,
  output logic [31:0] out_counter_value
);

  localparam logic [COUNTER_WIDTH-1:0] CNT_SAT = '1;

  logic [COUNTER_WIDTH-1:0] cnt_r   [NUM_COUNTERS];
  logic [COUNTER_WIDTH-1:0] cnt_nxt [NUM_COUNTERS];

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic [2:0]  cls_r, cls_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        omit_r, omit_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] value_r, value_nxt;

  logic                     take;
  logic [2:0]               cls;
  logic [5:0]               flags;
  logic [1:0]               status;
  logic                     omit;
  logic [15:0]              csum_fin;
  logic [COUNTER_WIDTH-1:0] len_ext;
  logic [COUNTER_WIDTH-1:0] rd_val;
  logic [CNT_W_MAX-1:0]     rd_wide;

  assign job_ready = !out_valid_r || out_ready;
  assign take      = job_valid && job_ready;
  assign csum_fin  = eac_add(eac_add(job.csum, job.udp_len), 16'(PROTO_UDP));
  assign len_ext   = COUNTER_WIDTH'(job.len);

  function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
    return (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

  always_comb begin
    cls    = CLS_OTHER;
    flags  = '0;
    status = CSUM_NONE;
    omit   = 1'b0;
    if (job.len < LEN_ETH_MIN) begin
      cls = CLS_TRUNC;
    end else if (!job.is_ip) begin
      cls = CLS_NON_IP;
    end else if (job.len < OFF_L4) begin
      cls = CLS_TRUNC;
    end else if (job.is_tcp) begin
      if (job.len < LEN_TCP_MIN) begin
        cls = CLS_TRUNC;
      end else begin
        cls   = CLS_TCP;
        flags = job.flags;
      end
    end else if (job.is_udp) begin
      if (job.len < LEN_UDP_MIN) begin
        cls = CLS_TRUNC;
      end else begin
        cls    = CLS_UDP;
        omit   = job.chk_zero;
        status = (job.payload_done && csum_fin == CSUM_GOOD) ? CSUM_OK : CSUM_BAD;
      end
    end
  end

  always_comb begin
    rd_val  = (job.idx < 5'(NUM_COUNTERS)) ? cnt_r[job.idx] : '0;
    rd_wide = CNT_W_MAX'(rd_val);
  end

  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (take && job.kind == KIND_FRAME) begin
      if (cnt_r[CNT_FRAMES] == '0 || len_ext < cnt_r[CNT_MIN_LEN]) begin
        cnt_nxt[CNT_MIN_LEN] = len_ext;
      end
      if (len_ext > cnt_r[CNT_MAX_LEN]) begin
        cnt_nxt[CNT_MAX_LEN] = len_ext;
      end
      cnt_nxt[CNT_FRAMES] = sat_inc(cnt_r[CNT_FRAMES]);
      if (job.len >= LEN_ETH_MIN && job.is_ip) cnt_nxt[CNT_IP] = sat_inc(cnt_r[CNT_IP]);
      if (cls == CLS_NON_IP) cnt_nxt[CNT_NON_IP] = sat_inc(cnt_r[CNT_NON_IP]);
      if (cls == CLS_TCP)    cnt_nxt[CNT_TCP]    = sat_inc(cnt_r[CNT_TCP]);
      if (cls == CLS_UDP)    cnt_nxt[CNT_UDP]    = sat_inc(cnt_r[CNT_UDP]);
      if (cls == CLS_OTHER)  cnt_nxt[CNT_OTHER]  = sat_inc(cnt_r[CNT_OTHER]);
      if (cls == CLS_TRUNC)  cnt_nxt[CNT_TRUNC]  = sat_inc(cnt_r[CNT_TRUNC]);
      for (int k = 0; k < 6; k++) begin
        if (flags[k]) cnt_nxt[CNT_FIN + k] = sat_inc(cnt_r[CNT_FIN + k]);
      end
      if (status == CSUM_OK)  cnt_nxt[CNT_CSUM_OK]  = sat_inc(cnt_r[CNT_CSUM_OK]);
      if (status == CSUM_BAD) cnt_nxt[CNT_CSUM_BAD] = sat_inc(cnt_r[CNT_CSUM_BAD]);
      if (omit) cnt_nxt[CNT_CSUM_OMIT] = sat_inc(cnt_r[CNT_CSUM_OMIT]);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    cls_nxt       = cls_r;
    flags_nxt     = flags_r;
    status_nxt    = status_r;
    omit_nxt      = omit_r;
    len_nxt       = len_r;
    value_nxt     = value_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = job.kind;
      if (job.kind == KIND_READ) begin
        cls_nxt    = '0;
        flags_nxt  = '0;
        status_nxt = CSUM_NONE;
        omit_nxt   = 1'b0;
        len_nxt    = '0;
        value_nxt  = (rd_wide > CNT_W_MAX'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : rd_wide[31:0];
      end else begin
        cls_nxt    = cls;
        flags_nxt  = flags;
        status_nxt = status;
        omit_nxt   = omit;
        len_nxt    = job.len;
        value_nxt  = '0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    cls_r    <= cls_nxt;
    flags_r  <= flags_nxt;
    status_r <= status_nxt;
    omit_r   <= omit_nxt;
    len_r    <= len_nxt;
    value_r  <= value_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = kind_r;
  assign out_frame_class      = cls_r;
  assign out_tcp_flag_bits    = flags_r;
  assign out_checksum_status  = status_r;
  assign out_checksum_omitted = omit_r;
  assign out_frame_length     = len_r;
  assign out_counter_value    = value_r;

endmodule

`default_nettype wire

// ===== sv/ethernet_ip_udp_packet_stats_core.sv =====
// a frame summary or counter read is registered in the job queue and then in the output register
// throughput: one beat per cycle while the job queue has room, since in_ready follows its push_ready
// a four-entry job queue lets the parser run on while the output is stalled
// reset: rst_n synchronous, clears parse state, queue, output valid flag and all counters
// ----------------------------------------------------------------------------
// ethernet_ip_udp_packet_stats_core
// ethernet/ipv4/udp frame statistics: per-frame classification, tcp flag and
// udp checksum checks, saturating counters read back by index
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_ip_udp_packet_stats_core import eius_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [4:0]  in_counter_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [2:0]       out_frame_class,
  output logic [5:0]       out_tcp_flag_bits,
  output logic [1:0]       out_checksum_status,
  output logic             out_checksum_omitted,
  output logic [15:0]      out_frame_length,
  output logic [31:0]      out_counter_value
);

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  eius_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .in_counter_index (in_counter_index),
    .job_valid        (fq_valid),
    .job              (fq_job),
    .job_ready        (fq_ready)
  );

  eius_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  eius_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .job_valid            (qb_valid),
    .job_ready            (qb_ready),
    .job                  (qb_job),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_frame_class      (out_frame_class),
    .out_tcp_flag_bits    (out_tcp_flag_bits),
    .out_checksum_status  (out_checksum_status),
    .out_checksum_omitted (out_checksum_omitted),
    .out_frame_length     (out_frame_length),
    .out_counter_value    (out_counter_value)
  );

endmodule

`default_nettype wire

// ===== sv/eius_checker.sv =====
// ----------------------------------------------------------------------------
// eius_checker
// port-level checks on the result channel of the frame statistics core
// ----------------------------------------------------------------------------
`default_nettype none

module eius_checker import eius_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_result_kind,
  input wire logic [2:0]  out_frame_class,
  input wire logic [5:0]  out_tcp_flag_bits,
  input wire logic [1:0]  out_checksum_status,
  input wire logic        out_checksum_omitted,
  input wire logic [15:0] out_frame_length,
  input wire logic [31:0] out_counter_value
);

  a_read_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_READ |->
      out_frame_class == CLS_NON_IP && out_tcp_flag_bits == 6'd0 &&
      out_checksum_status == CSUM_NONE && !out_checksum_omitted &&
      out_frame_length == 16'd0)
    else $error("counter read carries frame fields");

  a_frame_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_FRAME |->
      out_frame_length != 16'd0 && out_counter_value == 32'd0)
    else $error("frame summary with empty length or counter data");

  a_udp_only_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_FRAME |->
      ((out_frame_class == CLS_UDP) == (out_checksum_status != CSUM_NONE)) &&
      (out_frame_class == CLS_TCP || out_tcp_flag_bits == 6'd0) &&
      (out_frame_class == CLS_UDP || !out_checksum_omitted))
    else $error("checksum or flag fields disagree with frame class");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_result_kind) && $stable(out_frame_class) &&
      $stable(out_frame_length) && $stable(out_counter_value))
    else $error("stalled result changed");

endmodule

bind ethernet_ip_udp_packet_stats_core eius_checker u_eius_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_result_kind      (out_result_kind),
  .out_frame_class      (out_frame_class),
  .out_tcp_flag_bits    (out_tcp_flag_bits),
  .out_checksum_status  (out_checksum_status),
  .out_checksum_omitted (out_checksum_omitted),
  .out_frame_length     (out_frame_length),
  .out_counter_value    (out_counter_value)
);

`default_nettype wire
